// File: rtl/core/etc_pkg.sv
// Shared types and constants of the Euler TRS model-matrix builder.
`default_nettype none

package etc_pkg;

   // One request word: three binary angles, per-axis scale and position.
   typedef struct packed {
      logic [15:0]        angle_x;
      logic [15:0]        angle_y;
      logic [15:0]        angle_z;
      logic signed [31:0] scale_x;
      logic signed [31:0] scale_y;
      logic signed [31:0] scale_z;
      logic signed [31:0] pos_x;
      logic signed [31:0] pos_y;
      logic signed [31:0] pos_z;
   } req_type;

   // One response word: the twelve non-constant matrix entries.
   typedef struct packed {
      logic signed [31:0] m00;
      logic signed [31:0] m10;
      logic signed [31:0] m20;
      logic signed [31:0] m01;
      logic signed [31:0] m11;
      logic signed [31:0] m21;
      logic signed [31:0] m02;
      logic signed [31:0] m12;
      logic signed [31:0] m22;
      logic signed [31:0] trans_x;
      logic signed [31:0] trans_y;
      logic signed [31:0] trans_z;
   } rsp_type;

   // CORDIC datapath: x and y carry 30 fraction bits, z is in 2^32-per-turn units.
   localparam int CORDIC_W     = 34;
   localparam int CORDIC_FRAC  = 30;
   localparam int ATAN_ENTRIES = 24;

   localparam logic signed [CORDIC_W-1:0] CORDIC_GAIN  = 34'sd652032874;
   localparam logic signed [CORDIC_W-1:0] QUARTER_TURN = 34'sd1073741824;
   localparam logic signed [CORDIC_W-1:0] HALF_TURN    = 34'sd2147483648;

   localparam logic [31:0] ATAN_TABLE [ATAN_ENTRIES] = '{
      32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
      32'd42667331,  32'd21354465,  32'd10679838,  32'd5340245,
      32'd2670163,   32'd1335086,   32'd667544,    32'd333772,
      32'd166886,    32'd83443,     32'd41722,     32'd20861,
      32'd10430,     32'd5215,      32'd2608,      32'd1304,
      32'd652,       32'd326,       32'd163,       32'd81
   };

   // State handed from one CORDIC cell to the next.
   typedef struct packed {
      logic signed [CORDIC_W-1:0] x;
      logic signed [CORDIC_W-1:0] y;
      logic signed [CORDIC_W-1:0] z;
      logic                       flip;
   } cordic_type;

endpackage

`default_nettype wire

// File: rtl/core/etc_cordic_cell.sv
// One CORDIC rotation cell: a single micro-rotation followed by a register.
`default_nettype none

module etc_cordic_cell import etc_pkg::*; #(
   parameter int IDX = 0
) (
   input  logic       clock,
   input  cordic_type cell_i,
   output cordic_type cell_o
);

   cordic_type                 cell_ff, cell_in;
   logic signed [CORDIC_W-1:0] dx, dy, step;

   always_comb begin
      dx   = cell_i.y >>> IDX;
      dy   = cell_i.x >>> IDX;
      step = CORDIC_W'(ATAN_TABLE[IDX]);
      cell_in.flip = cell_i.flip;
      // A zero residual angle rotates in the positive direction.
      if (!cell_i.z[CORDIC_W-1]) begin
         cell_in.x = cell_i.x - dx;
         cell_in.y = cell_i.y + dy;
         cell_in.z = cell_i.z - step;
      end else begin
         cell_in.x = cell_i.x + dx;
         cell_in.y = cell_i.y - dy;
         cell_in.z = cell_i.z + step;
      end
   end

   always_ff @(posedge clock) begin
      cell_ff <= cell_in;
   end

   assign cell_o = cell_ff;

endmodule

`default_nettype wire

// File: rtl/core/etc_sincos.sv
// Sine and cosine of one binary angle: quadrant fold, chain of CORDIC cells, rounding.
`default_nettype none

module etc_sincos import etc_pkg::*; #(
   parameter int ANGLE_BITS    = 16,
   parameter int FRAC_BITS     = 16,
   parameter int CORDIC_STAGES = 16
) (
   input  logic                       clock,
   input  logic [15:0]                angle,
   output logic signed [FRAC_BITS+1:0] sin_o,
   output logic signed [FRAC_BITS+1:0] cos_o
);

   localparam int SC_W = FRAC_BITS + 2;
   localparam int SH   = CORDIC_FRAC - FRAC_BITS;
   localparam logic signed [CORDIC_W-1:0] RND = CORDIC_W'(64'd1 << (SH - 1));

   logic [31:0]                phase;
   logic signed [CORDIC_W-1:0] zs, xr, yr;
   cordic_type                 fold_ff, fold_in;
   cordic_type                 chain [CORDIC_STAGES+1];
   logic signed [SC_W-1:0]     sin_ff, sin_in, cos_ff, cos_in;

   always_comb begin
      phase = {16'b0, angle} << (32 - ANGLE_BITS);
      zs    = CORDIC_W'(signed'(phase));
      fold_in.x    = CORDIC_GAIN;
      fold_in.y    = '0;
      fold_in.z    = zs;
      fold_in.flip = 1'b0;
      // Beyond a quarter turn, rotate by a half turn and negate the results.
      if (zs > QUARTER_TURN || zs < -QUARTER_TURN) begin
         fold_in.flip = 1'b1;
         fold_in.z    = (zs > 0) ? zs - HALF_TURN : zs + HALF_TURN;
      end
   end

   always_ff @(posedge clock) begin
      fold_ff <= fold_in;
   end

   assign chain[0] = fold_ff;

   for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_cell
      etc_cordic_cell #(.IDX(i)) u_cell (
         .clock  (clock),
         .cell_i (chain[i]),
         .cell_o (chain[i+1])
      );
   end

   always_comb begin
      xr = (chain[CORDIC_STAGES].x + RND) >>> SH;
      yr = (chain[CORDIC_STAGES].y + RND) >>> SH;
      cos_in = chain[CORDIC_STAGES].flip ? -SC_W'(xr) : SC_W'(xr);
      sin_in = chain[CORDIC_STAGES].flip ? -SC_W'(yr) : SC_W'(yr);
   end

   always_ff @(posedge clock) begin
      sin_ff <= sin_in;
      cos_ff <= cos_in;
   end

   assign sin_o = sin_ff;
   assign cos_o = cos_ff;

endmodule

`default_nettype wire

// File: rtl/core/etc_matrix.sv
// Rotation composition, scaling and saturation: five pipeline stages.
`default_nettype none

module etc_matrix import etc_pkg::*; #(
   parameter int FRAC_BITS = 16
) (
   input  logic                        clock,
   input  logic signed [FRAC_BITS+1:0] sx,
   input  logic signed [FRAC_BITS+1:0] cx,
   input  logic signed [FRAC_BITS+1:0] sy,
   input  logic signed [FRAC_BITS+1:0] cy,
   input  logic signed [FRAC_BITS+1:0] sz,
   input  logic signed [FRAC_BITS+1:0] cz,
   input  req_type                     side,
   output rsp_type                     rsp_o
);

   localparam int SC_W = FRAC_BITS + 2;
   localparam int MP_W = 2 * SC_W;
   localparam int R_W  = SC_W + 1;
   localparam int PR_W = R_W + 32;
   localparam logic signed [MP_W-1:0] HALF_M  = MP_W'(64'd1 << (FRAC_BITS - 1));
   localparam logic signed [PR_W-1:0] HALF_P  = PR_W'(64'd1 << (FRAC_BITS - 1));
   localparam logic signed [PR_W-1:0] SAT_HI  = PR_W'(64'sh7FFFFFFF);
   localparam logic signed [PR_W-1:0] SAT_LO  = PR_W'(-64'sh80000000);

   function automatic logic signed [SC_W-1:0] mulq(input logic signed [SC_W-1:0] a,
                                                   input logic signed [SC_W-1:0] b);
      logic signed [MP_W-1:0] p;
      p = a * b + HALF_M;
      return SC_W'(p >>> FRAC_BITS);
   endfunction

   function automatic logic signed [31:0] scale_sat(input logic signed [PR_W-1:0] p);
      logic signed [PR_W-1:0] r;
      r = (p + HALF_P) >>> FRAC_BITS;
      if (r > SAT_HI) begin
         return 32'sh7FFFFFFF;
      end else if (r < SAT_LO) begin
         return 32'sh80000000;
      end else begin
         return 32'(r);
      end
   endfunction

   // Stage A: first-level products.
   logic signed [SC_W-1:0] sxsz_ff, sxcz_ff, cycz_a_ff, cxsz_a_ff, sycz_a_ff, cysz_a_ff;
   logic signed [SC_W-1:0] cxcz_a_ff, sysz_a_ff, sycx_a_ff, cycx_a_ff, sx_a_ff, sy_a_ff;
   logic signed [SC_W-1:0] cy_a_ff;
   req_type                side_a_ff;

   always_ff @(posedge clock) begin
      sxsz_ff   <= mulq(sx, sz);
      sxcz_ff   <= mulq(sx, cz);
      cycz_a_ff <= mulq(cy, cz);
      cxsz_a_ff <= mulq(cx, sz);
      sycz_a_ff <= mulq(sy, cz);
      cysz_a_ff <= mulq(cy, sz);
      cxcz_a_ff <= mulq(cx, cz);
      sysz_a_ff <= mulq(sy, sz);
      sycx_a_ff <= mulq(sy, cx);
      cycx_a_ff <= mulq(cy, cx);
      sx_a_ff   <= sx;
      sy_a_ff   <= sy;
      cy_a_ff   <= cy;
      side_a_ff <= side;
   end

   // Stage B: products that use the x-z terms.
   logic signed [SC_W-1:0] sy_sxsz_ff, cy_sxsz_ff, sy_sxcz_ff, cy_sxcz_ff;
   logic signed [SC_W-1:0] cycz_b_ff, cxsz_b_ff, sycz_b_ff, cysz_b_ff;
   logic signed [SC_W-1:0] cxcz_b_ff, sysz_b_ff, sycx_b_ff, cycx_b_ff, sx_b_ff;
   req_type                side_b_ff;

   always_ff @(posedge clock) begin
      sy_sxsz_ff <= mulq(sy_a_ff, sxsz_ff);
      cy_sxsz_ff <= mulq(cy_a_ff, sxsz_ff);
      sy_sxcz_ff <= mulq(sy_a_ff, sxcz_ff);
      cy_sxcz_ff <= mulq(cy_a_ff, sxcz_ff);
      cycz_b_ff  <= cycz_a_ff;
      cxsz_b_ff  <= cxsz_a_ff;
      sycz_b_ff  <= sycz_a_ff;
      cysz_b_ff  <= cysz_a_ff;
      cxcz_b_ff  <= cxcz_a_ff;
      sysz_b_ff  <= sysz_a_ff;
      sycx_b_ff  <= sycx_a_ff;
      cycx_b_ff  <= cycx_a_ff;
      sx_b_ff    <= sx_a_ff;
      side_b_ff  <= side_a_ff;
   end

   // Stage C: rotation entries, column-major.
   logic signed [R_W-1:0] r_ff [9];
   req_type               side_c_ff;

   always_ff @(posedge clock) begin
      r_ff[0]   <= R_W'(cycz_b_ff) + R_W'(sy_sxsz_ff);
      r_ff[1]   <= R_W'(cxsz_b_ff);
      r_ff[2]   <= R_W'(cy_sxsz_ff) - R_W'(sycz_b_ff);
      r_ff[3]   <= R_W'(sy_sxcz_ff) - R_W'(cysz_b_ff);
      r_ff[4]   <= R_W'(cxcz_b_ff);
      r_ff[5]   <= R_W'(sysz_b_ff) + R_W'(cy_sxcz_ff);
      r_ff[6]   <= R_W'(sycx_b_ff);
      r_ff[7]   <= -R_W'(sx_b_ff);
      r_ff[8]   <= R_W'(cycx_b_ff);
      side_c_ff <= side_b_ff;
   end

   // Stage D: multiply each column by its axis scale.
   logic signed [PR_W-1:0] p_ff [9];
   logic signed [31:0]     scl [3];
   req_type                side_d_ff;

   assign scl[0] = side_c_ff.scale_x;
   assign scl[1] = side_c_ff.scale_y;
   assign scl[2] = side_c_ff.scale_z;

   for (genvar k = 0; k < 9; k++) begin : g_scale
      always_ff @(posedge clock) begin
         p_ff[k] <= r_ff[k] * scl[k/3];
      end
   end

   always_ff @(posedge clock) begin
      side_d_ff <= side_c_ff;
   end

   // Stage E: round, saturate and register the response word.
   rsp_type rsp_ff, rsp_in;

   always_comb begin
      rsp_in.m00     = scale_sat(p_ff[0]);
      rsp_in.m10     = scale_sat(p_ff[1]);
      rsp_in.m20     = scale_sat(p_ff[2]);
      rsp_in.m01     = scale_sat(p_ff[3]);
      rsp_in.m11     = scale_sat(p_ff[4]);
      rsp_in.m21     = scale_sat(p_ff[5]);
      rsp_in.m02     = scale_sat(p_ff[6]);
      rsp_in.m12     = scale_sat(p_ff[7]);
      rsp_in.m22     = scale_sat(p_ff[8]);
      rsp_in.trans_x = side_d_ff.pos_x;
      rsp_in.trans_y = side_d_ff.pos_y;
      rsp_in.trans_z = side_d_ff.pos_z;
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign rsp_o = rsp_ff;

endmodule

`default_nettype wire

// File: rtl/core/euler_trs_matrix_compose.sv
// Top level of the Euler TRS model-matrix builder.
`default_nettype none

// Usage:
// A request word (three binary angles, axis scales and a position) is taken at
// a rising clock edge where start is high and busy is low. Busy is high only
// while reset is asserted, so one word may be issued in every clock cycle.
// Each word produces exactly one response word on rsp_data, marked by
// rsp_valid for a single cycle; the receiver must take it in that cycle.
// The response carries the nine rotation-times-scale entries and the
// translation column of a column-major 4x4 model matrix, rotation Ry*Rx*Rz.
// A word is registered in turn by the quadrant fold, one register per CORDIC
// cell, the rounding of sine and cosine, then five matrix stages (two product
// levels, the sums, the scale multiply, rounding with saturation).
// One word is taken per cycle except while reset holds busy high; the three
// CORDIC cell chains and the matrix pipeline all advance on every clock.
// Synchronous reset clears the valid pipeline, so words in flight are dropped
// and no response appears until a new word is taken.
module euler_trs_matrix_compose import etc_pkg::*; #(
   parameter int ANGLE_BITS    = 16,
   parameter int FRAC_BITS     = 16,
   parameter int CORDIC_STAGES = 16
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   output logic    busy,
   input  req_type req_data,
   output logic    rsp_valid,
   output rsp_type rsp_data
);

   localparam int SC_LAT = CORDIC_STAGES + 2;
   localparam int LAT    = SC_LAT + 5;

   logic accept;

   assign busy   = reset;
   assign accept = start & ~busy;

   // Valid bits that follow each word down the pipeline.
   logic [LAT-1:0] valid_ff, valid_in;

   assign valid_in = {valid_ff[LAT-2:0], accept};

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // Sine and cosine of each angle.
   logic signed [FRAC_BITS+1:0] sx, cx, sy, cy, sz, cz;

   etc_sincos #(.ANGLE_BITS(ANGLE_BITS), .FRAC_BITS(FRAC_BITS),
                .CORDIC_STAGES(CORDIC_STAGES)) u_sc_x (
      .clock (clock), .angle (req_data.angle_x), .sin_o (sx), .cos_o (cx)
   );

   etc_sincos #(.ANGLE_BITS(ANGLE_BITS), .FRAC_BITS(FRAC_BITS),
                .CORDIC_STAGES(CORDIC_STAGES)) u_sc_y (
      .clock (clock), .angle (req_data.angle_y), .sin_o (sy), .cos_o (cy)
   );

   etc_sincos #(.ANGLE_BITS(ANGLE_BITS), .FRAC_BITS(FRAC_BITS),
                .CORDIC_STAGES(CORDIC_STAGES)) u_sc_z (
      .clock (clock), .angle (req_data.angle_z), .sin_o (sz), .cos_o (cz)
   );

   // Scale and position wait alongside the CORDIC chains.
   req_type side_ff [SC_LAT];

   always_ff @(posedge clock) begin
      side_ff[0] <= req_data;
      for (int i = 1; i < SC_LAT; i++) begin
         side_ff[i] <= side_ff[i-1];
      end
   end

   etc_matrix #(.FRAC_BITS(FRAC_BITS)) u_matrix (
      .clock (clock),
      .sx    (sx),
      .cx    (cx),
      .sy    (sy),
      .cy    (cy),
      .sz    (sz),
      .cz    (cz),
      .side  (side_ff[SC_LAT-1]),
      .rsp_o (rsp_data)
   );

   assign rsp_valid = valid_ff[LAT-1];

   // Every accepted word is followed by its response on rsp_valid.
   a_accept_to_rsp: assert property (@(posedge clock) disable iff (reset)
      accept |-> ##LAT rsp_valid)
      else $error("accepted word produced no response");

   // A response only ever follows an accepted word.
   a_rsp_has_source: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(accept, LAT))
      else $error("response without accepted word");

   // The x and z translation entries line up with the word they came from.
   a_trans_aligned: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.trans_x == $past(req_data.pos_x, LAT)) &&
                    (rsp_data.trans_z == $past(req_data.pos_z, LAT)))
      else $error("translation misaligned with its word");

endmodule

`default_nettype wire

// File: tb/sv/euler_trs_matrix_compose_test.sv
// Self-checking testbench for the Euler TRS model-matrix builder.
`timescale 1ns / 100ps

module euler_trs_matrix_compose_test import etc_pkg::*;;

   localparam int LATENCY     = 16 + 7;
   localparam int CYCLE_LIMIT = 200000;
   localparam int RANDOM_WORDS = 1950;

   localparam logic signed [31:0] ONE  = 32'sd65536;
   localparam logic signed [31:0] QMAX = 32'sh7fffffff;
   localparam logic signed [31:0] QMIN = 32'sh80000000;

   // Angle codes used by the directed part.
   localparam logic [15:0] ANG_ZERO    = 16'h0000;
   localparam logic [15:0] ANG_QUARTER = 16'h4000;
   localparam logic [15:0] ANG_HALF    = 16'h8000;
   localparam logic [15:0] ANG_3QUART  = 16'hc000;
   localparam logic [15:0] ANG_LAST    = 16'hffff;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    start = 1'b0;
   logic    busy;
   req_type req_data = '0;
   logic    rsp_valid;
   rsp_type rsp_data;

   euler_trs_matrix_compose dut (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

   always #6 clock = ~clock;

   // Matrix words still owed by the block, oldest first.
   rsp_type pending_matrices[$];
   int      error_count = 0;
   int      cycle_count = 0;
   // Percent of cycles in which the sender holds off.
   int      send_idle_pct = 9;

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      $display("mismatch %s: got %h expected %h at cycle %0d", what, got, want,
               cycle_count);
      error_count++;
   endtask

   // Arithmetic shift right, which rounds toward minus infinity.
   function automatic longint floor_shr(input longint v, input int s);
      return v >>> s;
   endfunction

   function automatic longint round_shr(input longint v, input int s);
      return (v + (64'sd1 <<< (s - 1))) >>> s;
   endfunction

   function automatic longint qmul(input longint a, input longint b);
      return round_shr(a * b, 16);
   endfunction

   function automatic logic signed [31:0] clamp32(input longint v);
      if (v > 64'sd2147483647) return QMAX;
      if (v < -64'sd2147483648) return QMIN;
      return v[31:0];
   endfunction

   // Sine and cosine of a binary angle, Q2.16, via the 16-stage CORDIC.
   task automatic cordic_sincos(input logic [15:0] ang, output longint s,
                                output longint c);
      longint x, y, z, dx, dy;
      logic   flip;
      x = 652032874;
      y = 0;
      z = longint'($signed({ang, 16'h0000}));
      flip = 1'b0;
      if (z > 64'sd1073741824 || z < -64'sd1073741824) begin
         z += (z > 0) ? -64'sd2147483648 : 64'sd2147483648;
         flip = 1'b1;
      end
      for (int i = 0; i < 16; i++) begin
         dx = floor_shr(y, i);
         dy = floor_shr(x, i);
         if (z >= 0) begin
            x -= dx;
            y += dy;
            z -= longint'(ATAN_TABLE[i]);
         end else begin
            x += dx;
            y -= dy;
            z += longint'(ATAN_TABLE[i]);
         end
      end
      x = round_shr(x, 14);
      y = round_shr(y, 14);
      if (flip) begin
         x = -x;
         y = -y;
      end
      c = x;
      s = y;
   endtask

   // Builds the expected matrix word for one request word, R = Ry*Rx*Rz.
   task automatic compose_matrix(input req_type w, output rsp_type m);
      longint sx, cx, sy, cy, sz, cz, sxsz, sxcz;
      longint rot[9];
      longint scl[3];
      logic signed [31:0] ent[9];
      cordic_sincos(w.angle_x, sx, cx);
      cordic_sincos(w.angle_y, sy, cy);
      cordic_sincos(w.angle_z, sz, cz);
      sxsz = qmul(sx, sz);
      sxcz = qmul(sx, cz);
      rot[0] = qmul(cy, cz) + qmul(sy, sxsz);
      rot[1] = qmul(cx, sz);
      rot[2] = qmul(cy, sxsz) - qmul(sy, cz);
      rot[3] = qmul(sy, sxcz) - qmul(cy, sz);
      rot[4] = qmul(cx, cz);
      rot[5] = qmul(sy, sz) + qmul(cy, sxcz);
      rot[6] = qmul(sy, cx);
      rot[7] = -sx;
      rot[8] = qmul(cy, cx);
      scl[0] = w.scale_x;
      scl[1] = w.scale_y;
      scl[2] = w.scale_z;
      for (int k = 0; k < 9; k++)
         ent[k] = clamp32(round_shr(rot[k] * scl[k / 3], 16));
      m = '{ent[0], ent[1], ent[2], ent[3], ent[4], ent[5], ent[6], ent[7],
            ent[8], w.pos_x, w.pos_y, w.pos_z};
   endtask

   // Compares one response word against the oldest pending matrix.
   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid) begin
         if (pending_matrices.size() == 0) begin
            $display("unexpected response word at cycle %0d", cycle_count);
            error_count++;
         end else begin
            want = pending_matrices.pop_front();
            if (rsp_data.m00 !== want.m00) report_mismatch("m00", rsp_data.m00, want.m00);
            if (rsp_data.m10 !== want.m10) report_mismatch("m10", rsp_data.m10, want.m10);
            if (rsp_data.m20 !== want.m20) report_mismatch("m20", rsp_data.m20, want.m20);
            if (rsp_data.m01 !== want.m01) report_mismatch("m01", rsp_data.m01, want.m01);
            if (rsp_data.m11 !== want.m11) report_mismatch("m11", rsp_data.m11, want.m11);
            if (rsp_data.m21 !== want.m21) report_mismatch("m21", rsp_data.m21, want.m21);
            if (rsp_data.m02 !== want.m02) report_mismatch("m02", rsp_data.m02, want.m02);
            if (rsp_data.m12 !== want.m12) report_mismatch("m12", rsp_data.m12, want.m12);
            if (rsp_data.m22 !== want.m22) report_mismatch("m22", rsp_data.m22, want.m22);
            if (rsp_data.trans_x !== want.trans_x)
               report_mismatch("trans_x", rsp_data.trans_x, want.trans_x);
            if (rsp_data.trans_y !== want.trans_y)
               report_mismatch("trans_y", rsp_data.trans_y, want.trans_y);
            if (rsp_data.trans_z !== want.trans_z)
               report_mismatch("trans_z", rsp_data.trans_z, want.trans_z);
         end
      end
   end

   // Watchdog: a hung block ends the run as a failure.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("== FAIL ==");
         $finish;
      end
   end

   // Random word: mostly moderate scales so entries stay unsaturated, with
   // some full-range values to drive saturation and every bit.
   function automatic req_type random_word();
      logic [255:0] raw;
      req_type      w;
      raw = {$urandom, $urandom, $urandom, $urandom, $urandom,
             $urandom, $urandom, $urandom};
      w = req_type'(raw[$bits(req_type)-1:0]);
      if ($urandom_range(3) != 0) begin
         w.scale_x = $signed($urandom_range(32'h00080000)) - 32'sh00040000;
         w.scale_y = $signed($urandom_range(32'h00080000)) - 32'sh00040000;
         w.scale_z = $signed($urandom_range(32'h00080000)) - 32'sh00040000;
      end
      return w;
   endfunction

   // Issues one request word, idling at random before it, and holds start
   // high through the edge that takes it. The expected matrix comes either
   // from the directed table or from the predictor.
   task automatic issue_word(input req_type w, input bit typed,
                             input rsp_type typed_m);
      rsp_type m;
      while ($urandom_range(99) < send_idle_pct) begin
         start <= 1'b0;
         req_data <= random_word();
         @(posedge clock);
      end
      start <= 1'b1;
      req_data <= w;
      do @(posedge clock); while (busy);
      if (typed) m = typed_m;
      else compose_matrix(w, m);
      pending_matrices.push_back(m);
   endtask

   typedef struct {
      req_type word;
      bit      typed;
      rsp_type matrix;
   } directed_row;

   directed_row directed_rows[$];

   // Adds one directed row; typed rows carry the matrix read off by hand.
   function automatic void add_row(input logic [15:0] ax, ay, az,
                                   input logic signed [31:0] sc, px, py, pz,
                                   input bit typed, input rsp_type m);
      directed_row r;
      r.word = '{ax, ay, az, sc, sc, sc, px, py, pz};
      r.typed = typed;
      r.matrix = m;
      directed_rows.push_back(r);
   endfunction

   initial begin
      directed_row r;
      // Zero angles at unit scale come close to the identity; the CORDIC
      // leaves a small residual, so the predictor checks that row. Zero scale
      // gives a zero rotation block whatever the angles are.
      add_row(ANG_ZERO, ANG_ZERO, ANG_ZERO, ONE, 32'sd5, -32'sd7, 32'sd9, 1'b0,
              '0);
      add_row(ANG_LAST, ANG_QUARTER, ANG_HALF, 32'sd0, QMAX, QMIN, 32'sd0, 1'b1,
              '{0, 0, 0, 0, 0, 0, 0, 0, 0, QMAX, QMIN, 32'sd0});
      // Zero angles at extreme scales: the diagonal saturates or passes.
      add_row(ANG_ZERO, ANG_ZERO, ANG_ZERO, QMAX, QMIN, QMAX, -32'sd1, 1'b0, '0);
      add_row(ANG_ZERO, ANG_ZERO, ANG_ZERO, QMIN, 32'sd1, 32'sd2, 32'sd3, 1'b0, '0);
      // Quadrant edges on each axis, both folds, and the top angle code.
      add_row(ANG_QUARTER, ANG_ZERO, ANG_ZERO, ONE, 0, 0, 0, 1'b0, '0);
      add_row(ANG_ZERO, ANG_QUARTER, ANG_ZERO, ONE, 0, 0, 0, 1'b0, '0);
      add_row(ANG_ZERO, ANG_ZERO, ANG_QUARTER, ONE, 0, 0, 0, 1'b0, '0);
      add_row(ANG_HALF, ANG_HALF, ANG_HALF, ONE, 0, 0, 0, 1'b0, '0);
      add_row(ANG_3QUART, ANG_3QUART, ANG_3QUART, -ONE, 0, 0, 0, 1'b0, '0);
      add_row(ANG_LAST, ANG_LAST, ANG_LAST, ONE, 0, 0, 0, 1'b0, '0);
      add_row(16'h4001, 16'hbfff, 16'h3fff, ONE, 0, 0, 0, 1'b0, '0);
      add_row(16'hc001, 16'h8001, 16'h7fff, 32'sd3, 0, 0, 0, 1'b0, '0);
      add_row(16'h2000, 16'h6000, 16'ha000, QMAX, 0, 0, 0, 1'b0, '0);
      add_row(16'he000, 16'h1234, 16'h5555, QMIN, 0, 0, 0, 1'b0, '0);
      add_row(16'h0001, 16'hfffe, 16'h8000, 32'sh00020000, 0, 0, 0, 1'b0, '0);

      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed_rows[i]) begin
         r = directed_rows[i];
         issue_word(r.word, r.typed, r.matrix);
      end

      // Three random phases: sender idles lightly, then heavily, then never.
      for (int phase = 0; phase < 3; phase++) begin
         send_idle_pct = (phase == 0) ? 9 : (phase == 1) ? 65 : 0;
         for (int n = 0; n < RANDOM_WORDS / 3; n++) begin
            issue_word(random_word(), 1'b0, '0);
            // Once per phase, drain the pipeline completely before going on.
            if (n == RANDOM_WORDS / 6) begin
               start <= 1'b0;
               while (pending_matrices.size() != 0) @(posedge clock);
            end
         end
      end
      start <= 1'b0;

      while (pending_matrices.size() != 0) @(posedge clock);
      repeat (LATENCY + 5) @(posedge clock);
      if (error_count == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule
